// ===== sv/piv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piv_pkg: shared types, constants and microcode for the point-in-volume test
// Holds the sizes of the limb multiplier, the command and status structs that
// join controller and datapath, the tolerance constants and the micro-program.
// ----------------------------------------------------------------------------
package piv_pkg;

  localparam int VOLUME_WORDS_DEF = 16;
  localparam int WORD_LIMIT       = 15;

  localparam int LIMB_W  = 32;
  localparam int NLIMB   = 5;
  localparam int MAG_W   = LIMB_W * NLIMB;
  localparam int LIMB_CW = $clog2(NLIMB);
  localparam int REG_W   = 136;
  localparam int ACC_W   = 200;
  localparam int NREG    = 12;
  localparam int RF_AW   = $clog2(NREG);
  localparam int PC_W    = 7;

  // Volume kinds.
  localparam logic [1:0] KIND_BOX      = 2'd0;
  localparam logic [1:0] KIND_CYLINDER = 2'd1;
  localparam logic [1:0] KIND_SPHERE   = 2'd2;
  localparam logic [1:0] KIND_INVALID  = 2'd3;

  // Micro-operations.
  localparam logic [2:0] OP_SUBP  = 3'd0;
  localparam logic [2:0] OP_LDW   = 3'd1;
  localparam logic [2:0] OP_MAC   = 3'd2;
  localparam logic [2:0] OP_ADDK  = 3'd3;
  localparam logic [2:0] OP_STORE = 3'd4;
  localparam logic [2:0] OP_TEST  = 3'd5;
  localparam logic [2:0] OP_FAIL  = 3'd6;
  localparam logic [2:0] OP_END   = 3'd7;

  // Operand sources: register file entries, then special sources.
  localparam logic [3:0] R_D0 = 4'd0;
  localparam logic [3:0] R_D1 = 4'd1;
  localparam logic [3:0] R_D2 = 4'd2;
  localparam logic [3:0] R_A0 = 4'd3;
  localparam logic [3:0] R_A1 = 4'd4;
  localparam logic [3:0] R_A2 = 4'd5;
  localparam logic [3:0] R_L  = 4'd6;
  localparam logic [3:0] R_B  = 4'd7;
  localparam logic [3:0] R_C0 = 4'd8;
  localparam logic [3:0] R_C1 = 4'd9;
  localparam logic [3:0] R_C2 = 4'd10;
  localparam logic [3:0] R_T  = 4'd11;
  localparam logic [3:0] S_W     = 4'd12;
  localparam logic [3:0] S_K1    = 4'd13;
  localparam logic [3:0] S_K4096 = 4'd14;

  // Point components.
  localparam logic [1:0] P_X = 2'd0;
  localparam logic [1:0] P_Y = 2'd1;
  localparam logic [1:0] P_Z = 2'd2;

  // Accumulator constants.
  localparam logic [2:0] K_EPS24 = 3'd0;
  localparam logic [2:0] K_EPS36 = 3'd1;
  localparam logic [2:0] K_EPS48 = 3'd2;
  localparam logic [2:0] K_EPS72 = 3'd3;
  localparam logic [2:0] K_NDEG  = 3'd4;

  // Program entry points.
  localparam logic [PC_W-1:0] PC_BOX      = 7'd0;
  localparam logic [PC_W-1:0] PC_SPHERE   = 7'd37;
  localparam logic [PC_W-1:0] PC_CYLINDER = 7'd47;
  localparam logic [PC_W-1:0] PC_INVALID  = 7'd92;
  localparam logic [PC_W-1:0] PC_LAST     = 7'd93;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] dst;
    logic [3:0] word;
    logic [1:0] pk;
    logic [2:0] kc;
    logic       neg;
    logic       clr;
  } uop_t;

  typedef struct packed {
    uop_t               u;
    logic               load_point;
    logic               wr_word;
    logic               exec;
    logic               lat_a;
    logic               lat_b;
    logic               mul_go;
    logic [LIMB_CW-1:0] li;
    logic [LIMB_CW-1:0] lj;
    logic [RF_AW-1:0]   rf_raddr;
  } cmd_t;

  typedef struct packed {
    logic pass;
  } status_t;

  function automatic uop_t u_subp(logic [3:0] dst, logic [1:0] pk, logic [3:0] word);
    uop_t u;
    u = '0;
    u.op = OP_SUBP;
    u.dst = dst;
    u.pk = pk;
    u.word = word;
    return u;
  endfunction

  function automatic uop_t u_ldw(logic [3:0] dst, logic [3:0] word);
    uop_t u;
    u = '0;
    u.op = OP_LDW;
    u.dst = dst;
    u.word = word;
    return u;
  endfunction

  function automatic uop_t u_mac(logic [3:0] a, logic [3:0] b, logic neg, logic clr,
                                 logic [3:0] word);
    uop_t u;
    u = '0;
    u.op = OP_MAC;
    u.a = a;
    u.b = b;
    u.neg = neg;
    u.clr = clr;
    u.word = word;
    return u;
  endfunction

  function automatic uop_t u_op(logic [2:0] op, logic [2:0] kc, logic [3:0] dst);
    uop_t u;
    u = '0;
    u.op = op;
    u.kc = kc;
    u.dst = dst;
    return u;
  endfunction

  // Tolerance 0.0001 at 24, 36, 48 and 72 fraction bits; NDEG rejects a
  // cylinder whose squared axis length does not exceed the tolerance.
  function automatic logic signed [ACC_W-1:0] k_value(logic [2:0] kc);
    logic signed [ACC_W-1:0] r;
    unique case (kc)
      K_EPS24: r = ACC_W'(64'sd1678);
      K_EPS36: r = ACC_W'(64'sd6871948);
      K_EPS48: r = ACC_W'(64'sd28147497671);
      K_EPS72: r = ACC_W'(64'sd472236648286964521);
      K_NDEG:  r = ACC_W'(-64'sd28147497672);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Every check leaves its margin in the accumulator; a negative margin fails.
  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      // Box
      7'd0:  u = u_subp(R_D0, P_X, 4'd9);
      7'd1:  u = u_subp(R_D1, P_Y, 4'd10);
      7'd2:  u = u_subp(R_D2, P_Z, 4'd11);
      7'd3:  u = u_mac(S_W, R_D0, 1'b0, 1'b1, 4'd0);
      7'd4:  u = u_mac(S_W, R_D1, 1'b0, 1'b0, 4'd1);
      7'd5:  u = u_mac(S_W, R_D2, 1'b0, 1'b0, 4'd2);
      7'd6:  u = u_op(OP_ADDK, K_EPS24, R_D0);
      7'd7:  u = u_op(OP_TEST, K_EPS24, R_D0);
      7'd8:  u = u_mac(S_W, S_K4096, 1'b0, 1'b1, 4'd12);
      7'd9:  u = u_op(OP_ADDK, K_EPS24, R_D0);
      7'd10: u = u_mac(S_W, R_D0, 1'b1, 1'b0, 4'd0);
      7'd11: u = u_mac(S_W, R_D1, 1'b1, 1'b0, 4'd1);
      7'd12: u = u_mac(S_W, R_D2, 1'b1, 1'b0, 4'd2);
      7'd13: u = u_op(OP_TEST, K_EPS24, R_D0);
      7'd14: u = u_mac(S_W, R_D0, 1'b0, 1'b1, 4'd3);
      7'd15: u = u_mac(S_W, R_D1, 1'b0, 1'b0, 4'd4);
      7'd16: u = u_mac(S_W, R_D2, 1'b0, 1'b0, 4'd5);
      7'd17: u = u_op(OP_ADDK, K_EPS24, R_D0);
      7'd18: u = u_op(OP_TEST, K_EPS24, R_D0);
      7'd19: u = u_mac(S_W, S_K4096, 1'b0, 1'b1, 4'd13);
      7'd20: u = u_op(OP_ADDK, K_EPS24, R_D0);
      7'd21: u = u_mac(S_W, R_D0, 1'b1, 1'b0, 4'd3);
      7'd22: u = u_mac(S_W, R_D1, 1'b1, 1'b0, 4'd4);
      7'd23: u = u_mac(S_W, R_D2, 1'b1, 1'b0, 4'd5);
      7'd24: u = u_op(OP_TEST, K_EPS24, R_D0);
      7'd25: u = u_mac(S_W, R_D0, 1'b0, 1'b1, 4'd6);
      7'd26: u = u_mac(S_W, R_D1, 1'b0, 1'b0, 4'd7);
      7'd27: u = u_mac(S_W, R_D2, 1'b0, 1'b0, 4'd8);
      7'd28: u = u_op(OP_ADDK, K_EPS24, R_D0);
      7'd29: u = u_op(OP_TEST, K_EPS24, R_D0);
      7'd30: u = u_mac(S_W, S_K4096, 1'b0, 1'b1, 4'd14);
      7'd31: u = u_op(OP_ADDK, K_EPS24, R_D0);
      7'd32: u = u_mac(S_W, R_D0, 1'b1, 1'b0, 4'd6);
      7'd33: u = u_mac(S_W, R_D1, 1'b1, 1'b0, 4'd7);
      7'd34: u = u_mac(S_W, R_D2, 1'b1, 1'b0, 4'd8);
      7'd35: u = u_op(OP_TEST, K_EPS24, R_D0);
      7'd36: u = u_op(OP_END, K_EPS24, R_D0);
      // Sphere
      7'd37: u = u_subp(R_D0, P_X, 4'd0);
      7'd38: u = u_subp(R_D1, P_Y, 4'd1);
      7'd39: u = u_subp(R_D2, P_Z, 4'd2);
      7'd40: u = u_mac(S_W, S_W, 1'b0, 1'b1, 4'd3);
      7'd41: u = u_op(OP_ADDK, K_EPS24, R_D0);
      7'd42: u = u_mac(R_D0, R_D0, 1'b1, 1'b0, 4'd0);
      7'd43: u = u_mac(R_D1, R_D1, 1'b1, 1'b0, 4'd0);
      7'd44: u = u_mac(R_D2, R_D2, 1'b1, 1'b0, 4'd0);
      7'd45: u = u_op(OP_TEST, K_EPS24, R_D0);
      7'd46: u = u_op(OP_END, K_EPS24, R_D0);
      // Cylinder: scaled axis and its squared length
      7'd47: u = u_ldw(R_T, 4'd7);
      7'd48: u = u_mac(S_W, R_T, 1'b0, 1'b1, 4'd0);
      7'd49: u = u_op(OP_STORE, K_EPS24, R_A0);
      7'd50: u = u_mac(S_W, R_T, 1'b0, 1'b1, 4'd1);
      7'd51: u = u_op(OP_STORE, K_EPS24, R_A1);
      7'd52: u = u_mac(S_W, R_T, 1'b0, 1'b1, 4'd2);
      7'd53: u = u_op(OP_STORE, K_EPS24, R_A2);
      7'd54: u = u_mac(R_A0, R_A0, 1'b0, 1'b1, 4'd0);
      7'd55: u = u_mac(R_A1, R_A1, 1'b0, 1'b0, 4'd0);
      7'd56: u = u_mac(R_A2, R_A2, 1'b0, 1'b0, 4'd0);
      7'd57: u = u_op(OP_STORE, K_EPS24, R_L);
      7'd58: u = u_op(OP_ADDK, K_NDEG, R_D0);
      7'd59: u = u_op(OP_TEST, K_EPS24, R_D0);
      // Projection onto the axis
      7'd60: u = u_subp(R_D0, P_X, 4'd3);
      7'd61: u = u_subp(R_D1, P_Y, 4'd4);
      7'd62: u = u_subp(R_D2, P_Z, 4'd5);
      7'd63: u = u_mac(R_D0, R_A0, 1'b0, 1'b1, 4'd0);
      7'd64: u = u_mac(R_D1, R_A1, 1'b0, 1'b0, 4'd0);
      7'd65: u = u_mac(R_D2, R_A2, 1'b0, 1'b0, 4'd0);
      7'd66: u = u_op(OP_STORE, K_EPS24, R_B);
      7'd67: u = u_op(OP_ADDK, K_EPS36, R_D0);
      7'd68: u = u_op(OP_TEST, K_EPS24, R_D0);
      7'd69: u = u_mac(R_L, S_K1, 1'b0, 1'b1, 4'd0);
      7'd70: u = u_op(OP_ADDK, K_EPS48, R_D0);
      7'd71: u = u_mac(R_B, S_K4096, 1'b1, 1'b0, 4'd0);
      7'd72: u = u_op(OP_TEST, K_EPS24, R_D0);
      // Cross product for the radial distance
      7'd73: u = u_mac(R_D1, R_A2, 1'b0, 1'b1, 4'd0);
      7'd74: u = u_mac(R_D2, R_A1, 1'b1, 1'b0, 4'd0);
      7'd75: u = u_op(OP_STORE, K_EPS24, R_C0);
      7'd76: u = u_mac(R_D2, R_A0, 1'b0, 1'b1, 4'd0);
      7'd77: u = u_mac(R_D0, R_A2, 1'b1, 1'b0, 4'd0);
      7'd78: u = u_op(OP_STORE, K_EPS24, R_C1);
      7'd79: u = u_mac(R_D0, R_A1, 1'b0, 1'b1, 4'd0);
      7'd80: u = u_mac(R_D1, R_A0, 1'b1, 1'b0, 4'd0);
      7'd81: u = u_op(OP_STORE, K_EPS24, R_C2);
      7'd82: u = u_ldw(R_T, 4'd6);
      7'd83: u = u_mac(R_T, R_T, 1'b0, 1'b1, 4'd0);
      7'd84: u = u_op(OP_STORE, K_EPS24, R_T);
      7'd85: u = u_mac(R_T, R_L, 1'b0, 1'b1, 4'd0);
      7'd86: u = u_op(OP_ADDK, K_EPS72, R_D0);
      7'd87: u = u_mac(R_C0, R_C0, 1'b1, 1'b0, 4'd0);
      7'd88: u = u_mac(R_C1, R_C1, 1'b1, 1'b0, 4'd0);
      7'd89: u = u_mac(R_C2, R_C2, 1'b1, 1'b0, 4'd0);
      7'd90: u = u_op(OP_TEST, K_EPS24, R_D0);
      7'd91: u = u_op(OP_END, K_EPS24, R_D0);
      // Invalid kind
      7'd92: u = u_op(OP_FAIL, K_EPS24, R_D0);
      default: u = u_op(OP_END, K_EPS24, R_D0);
    endcase
    return u;
  endfunction

endpackage

// ===== sv/point_in_volume_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_volume_test: is a 3-D point inside a box, cylinder or sphere
// Write requests load the volume's Q19.12 words; test requests return one
// inside flag computed exactly with a shared 32x32 limb multiplier.
//
//   channel  handshake                 payload
//   cfg      cfg_wr_en                 cfg_wr_data (volume kind)
//   in       in_valid / in_stall       action, word_index, word_value, point_x/y/z
//   out      out_valid / out_stall     inside_res
//
// A write request is stored directly. A test request runs a micro-program in
// which every multiply-accumulate steps through fetch, operand, execute,
// 25 limb products of the 32x32 multiplier and drain; other steps go
// through fetch and execute. Reset is synchronous and needs no clearing
// pass; the kind resets to invalid. in_stall is high while a test runs
// and while its result waits for the output register; a finished result
// waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module point_in_volume_test #(
  parameter int VOLUME_WORDS = piv_pkg::VOLUME_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [3:0]         word_index,
  input  logic signed [31:0] word_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               inside_res
);

  piv_pkg::cmd_t    cmd;
  piv_pkg::status_t status;

  piv_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .inside_res  (inside_res),
    .cmd         (cmd),
    .status      (status)
  );

  piv_dp #(.VOLUME_WORDS(VOLUME_WORDS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .word_index (word_index),
    .word_value (word_value),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .status     (status)
  );

endmodule

// ===== sv/piv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piv_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module piv_ram #(
  parameter int WIDTH = piv_pkg::LIMB_W,
  parameter int DEPTH = piv_pkg::VOLUME_WORDS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/piv_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piv_dp: datapath of the point-in-volume test
// Volume word store, operand register file, a 32x32 limb multiplier feeding
// a 200-bit signed accumulator, and the pass flag of the current test.
// ----------------------------------------------------------------------------
module piv_dp #(
  parameter int VOLUME_WORDS = piv_pkg::VOLUME_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  piv_pkg::cmd_t       cmd,
  input  logic [3:0]          word_index,
  input  logic signed [31:0]  word_value,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  output piv_pkg::status_t    status
);

  localparam int VW_AW = $clog2(VOLUME_WORDS);

  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic signed [31:0] p_sel;

  logic        word_we;
  logic [31:0] word_q;
  logic signed [piv_pkg::REG_W-1:0] w_ext;

  logic                             rf_we;
  logic [piv_pkg::REG_W-1:0]        rf_wdata;
  logic [piv_pkg::REG_W-1:0]        rf_q;

  logic [3:0]                       src;
  logic signed [piv_pkg::REG_W-1:0] opnd;
  logic                             opnd_neg;
  logic [piv_pkg::REG_W-1:0]        opnd_mag;

  logic [piv_pkg::MAG_W-1:0]        mag_a;
  logic [piv_pkg::MAG_W-1:0]        mag_b;
  logic                             sign_a;
  logic                             prod_neg;
  logic [2*piv_pkg::LIMB_W-1:0]     prod;
  logic [piv_pkg::LIMB_CW:0]        prod_sh;
  logic                             prod_vld;
  logic [piv_pkg::ACC_W-1:0]        prod_wide;

  logic signed [piv_pkg::ACC_W-1:0] acc;
  logic signed [piv_pkg::ACC_W-1:0] acc_next;
  logic                             pass;

  assign word_we = cmd.wr_word && (word_index < 4'(piv_pkg::WORD_LIMIT))
                   && (32'(word_index) < VOLUME_WORDS);

  piv_ram #(.WIDTH(32), .DEPTH(VOLUME_WORDS)) u_words (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_index[VW_AW-1:0]),
    .wdata (word_value),
    .raddr (cmd.u.word[VW_AW-1:0]),
    .rdata (word_q)
  );

  piv_ram #(.WIDTH(piv_pkg::REG_W), .DEPTH(piv_pkg::NREG)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (cmd.u.dst[piv_pkg::RF_AW-1:0]),
    .wdata (rf_wdata),
    .raddr (cmd.rf_raddr),
    .rdata (rf_q)
  );

  assign w_ext = piv_pkg::REG_W'($signed(word_q));

  always_comb begin
    unique case (cmd.u.pk)
      piv_pkg::P_X: p_sel = px;
      piv_pkg::P_Y: p_sel = py;
      default:      p_sel = pz;
    endcase
  end

  assign rf_we = cmd.exec && ((cmd.u.op == piv_pkg::OP_SUBP) ||
                              (cmd.u.op == piv_pkg::OP_LDW) ||
                              (cmd.u.op == piv_pkg::OP_STORE));

  always_comb begin
    unique case (cmd.u.op)
      piv_pkg::OP_SUBP: rf_wdata = piv_pkg::REG_W'(p_sel) - w_ext;
      piv_pkg::OP_LDW:  rf_wdata = w_ext;
      default:          rf_wdata = acc[piv_pkg::REG_W-1:0];
    endcase
  end

  // Operand A is latched in the cycle after its fetch, operand B in the execute state after that.
  assign src = cmd.lat_a ? cmd.u.a : cmd.u.b;

  always_comb begin
    unique case (src)
      piv_pkg::S_W:     opnd = w_ext;
      piv_pkg::S_K1:    opnd = piv_pkg::REG_W'(1);
      piv_pkg::S_K4096: opnd = piv_pkg::REG_W'(4096);
      default:          opnd = $signed(rf_q);
    endcase
  end

  assign opnd_neg = opnd[piv_pkg::REG_W-1];
  assign opnd_mag = opnd_neg ? piv_pkg::REG_W'(-opnd) : piv_pkg::REG_W'(opnd);

  assign prod_wide = piv_pkg::ACC_W'(prod) << (piv_pkg::LIMB_W * prod_sh);

  always_comb begin
    unique if (cmd.exec && (cmd.u.op == piv_pkg::OP_MAC) && cmd.u.clr) begin
      acc_next = '0;
    end else if (cmd.exec && (cmd.u.op == piv_pkg::OP_ADDK)) begin
      acc_next = acc + piv_pkg::k_value(cmd.u.kc);
    end else if (prod_vld) begin
      acc_next = prod_neg ? acc - $signed(prod_wide) : acc + $signed(prod_wide);
    end else begin
      acc_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      pass     <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_go;
      if (cmd.load_point) begin
        pass <= 1'b1;
      end else if (cmd.exec && ((cmd.u.op == piv_pkg::OP_FAIL) ||
                                ((cmd.u.op == piv_pkg::OP_TEST) &&
                                 acc[piv_pkg::ACC_W-1]))) begin
        pass <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (cmd.load_point) begin
      px <= point_x;
      py <= point_y;
      pz <= point_z;
    end
    if (cmd.lat_a) begin
      mag_a  <= piv_pkg::MAG_W'(opnd_mag);
      sign_a <= opnd_neg;
    end
    if (cmd.lat_b) begin
      mag_b    <= piv_pkg::MAG_W'(opnd_mag);
      prod_neg <= sign_a ^ opnd_neg ^ cmd.u.neg;
    end
    if (cmd.mul_go) begin
      prod    <= mag_a[cmd.li*piv_pkg::LIMB_W +: piv_pkg::LIMB_W] *
                 mag_b[cmd.lj*piv_pkg::LIMB_W +: piv_pkg::LIMB_W];
      prod_sh <= {1'b0, cmd.li} + {1'b0, cmd.lj};
    end
  end

  assign status.pass = pass;

endmodule

// ===== sv/piv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piv_ctrl: sequencer of the point-in-volume test
// Accepts requests, holds the volume kind, steps the micro-program and the
// limb loop of each multiply-accumulate, and owns the result register.
// ----------------------------------------------------------------------------
module piv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             action,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             inside_res,
  output piv_pkg::cmd_t    cmd,
  input  piv_pkg::status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_OPA   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [piv_pkg::LIMB_CW-1:0] LIMB_LAST = piv_pkg::LIMB_CW'(piv_pkg::NLIMB - 1);

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [piv_pkg::PC_W-1:0]       pc;
  logic [piv_pkg::PC_W-1:0]       pc_next;
  logic [piv_pkg::PC_W-1:0]       pc_start;
  logic [piv_pkg::LIMB_CW-1:0]    li;
  logic [piv_pkg::LIMB_CW-1:0]    li_next;
  logic [piv_pkg::LIMB_CW-1:0]    lj;
  logic [piv_pkg::LIMB_CW-1:0]    lj_next;
  logic [1:0]                     volume_kind;
  logic                           in_acc;
  logic                           out_load;
  piv_pkg::uop_t                  u;

  assign u        = piv_pkg::uop_rom(pc);
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    unique case (volume_kind)
      piv_pkg::KIND_BOX:      pc_start = piv_pkg::PC_BOX;
      piv_pkg::KIND_CYLINDER: pc_start = piv_pkg::PC_CYLINDER;
      piv_pkg::KIND_SPHERE:   pc_start = piv_pkg::PC_SPHERE;
      default:                pc_start = piv_pkg::PC_INVALID;
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    li_next    = li;
    lj_next    = lj;
    unique case (state)
      S_IDLE: begin
        if (in_acc && action) begin
          pc_next    = pc_start;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = (u.op == piv_pkg::OP_MAC) ? S_OPA : S_EXEC;
      end
      S_OPA: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (u.op == piv_pkg::OP_MAC) begin
          li_next    = '0;
          lj_next    = '0;
          state_next = S_MUL;
        end else if (u.op == piv_pkg::OP_END) begin
          state_next = S_DONE;
        end else begin
          pc_next    = pc + piv_pkg::PC_W'(1);
          state_next = S_FETCH;
        end
      end
      S_MUL: begin
        if (lj == LIMB_LAST) begin
          lj_next = '0;
          if (li == LIMB_LAST) begin
            state_next = S_DRAIN;
          end else begin
            li_next = li + piv_pkg::LIMB_CW'(1);
          end
        end else begin
          lj_next = lj + piv_pkg::LIMB_CW'(1);
        end
      end
      S_DRAIN: begin
        // The last partial product lands in the accumulator in this cycle.
        pc_next    = pc + piv_pkg::PC_W'(1);
        state_next = S_FETCH;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pc          <= '0;
      li          <= '0;
      lj          <= '0;
      volume_kind <= piv_pkg::KIND_INVALID;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      li    <= li_next;
      lj    <= lj_next;
      if (cfg_wr_en) begin
        volume_kind <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      inside_res <= status.pass;
    end
  end

  always_comb begin
    cmd.u          = u;
    cmd.load_point = in_acc && action;
    cmd.wr_word    = in_acc && !action;
    cmd.exec       = (state == S_EXEC);
    cmd.lat_a      = (state == S_OPA);
    cmd.lat_b      = (state == S_EXEC) && (u.op == piv_pkg::OP_MAC);
    cmd.mul_go     = (state == S_MUL);
    cmd.li         = li;
    cmd.lj         = lj;
    cmd.rf_raddr   = (state == S_OPA) ? u.b[piv_pkg::RF_AW-1:0] : u.a[piv_pkg::RF_AW-1:0];
  end

  a_mul_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> state == S_MUL || state == S_DRAIN)
    else $error("limb loop left without draining");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> $past(li) == LIMB_LAST && $past(state) == S_MUL)
    else $error("drain before the last limb product");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> pc <= piv_pkg::PC_LAST)
    else $error("program counter outside the micro-program");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");

  a_test_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action |=> state == S_FETCH)
    else $error("accepted test request did not start the program");

endmodule
